@@ rtl/core/bbr_pkg.sv @@
package bbr_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int REF_BITS      = 8;
   // slot and entry fields are four bits wide, so at most sixteen entries are reachable
   localparam int USED_ENTRIES  = (TABLE_ENTRIES < 16) ? TABLE_ENTRIES : 16;
   localparam int USED_W        = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;

   // field widths
   localparam int MODE_W     = 2;
   localparam int BLOCK_W    = 16;
   localparam int ENTRY_W    = 4;
   localparam int ACTION_W   = 3;
   localparam int SLOT_W     = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef logic [REF_BITS-1:0] refs_type;
   typedef logic [BLOCK_W-1:0]  block_type;
   typedef logic [USED_W-1:0]   index_type;

   localparam refs_type REF_MAX = '1;
   localparam refs_type REF_ONE = refs_type'(1);

   // request modes
   localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUT    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // result actions
   localparam logic [ACTION_W-1:0] ACT_HIT       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC     = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FULL      = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RELEASED  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_WRITEBACK = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_FLUSH     = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_DONE      = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_ERROR     = 3'd7;

   // controller to datapath
   typedef struct packed {
      logic latch;       // capture the request transaction
      logic exec;        // resolve a get, put or unused mode and load its result
      logic flush_step;  // examine the scanned entry, load a flush write if active
      logic flush_done;  // load the closing done result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic scan_active;
      logic scan_last;
   } status_type;

endpackage

@@ rtl/core/bbr_ctrl.sv @@
module bbr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bbr_pkg::MODE_W-1:0]    req_mode,
   input  bbr_pkg::status_type           status,
   output bbr_pkg::cmd_type              cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = (req_mode == bbr_pkg::MODE_FLUSH) ? ST_FLUSH : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            // free entries are skipped without waiting on the output
            if (!status.scan_active || status.out_free) begin
               cmd.flush_step = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.flush_done = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/bbr_dpath.sv @@
module bbr_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  bbr_pkg::cmd_type                 cmd,
   output bbr_pkg::status_type              status,
   input  logic [bbr_pkg::MODE_W-1:0]       req_mode,
   input  logic [bbr_pkg::BLOCK_W-1:0]      req_block,
   input  logic [bbr_pkg::ENTRY_W-1:0]      req_entry,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bbr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [bbr_pkg::ACTION_W-1:0]     rsp_tuser,
   output logic                             rsp_tlast
);

   // latched request
   logic [bbr_pkg::MODE_W-1:0]  mode_ff;
   bbr_pkg::block_type          blk_ff;
   logic [bbr_pkg::ENTRY_W-1:0] idx_ff;
   bbr_pkg::index_type          scan_ff;

   // table
   bbr_pkg::refs_type  refs_ff  [bbr_pkg::USED_ENTRIES];
   bbr_pkg::block_type block_ff [bbr_pkg::USED_ENTRIES];

   // output register
   logic                          out_valid_ff;
   logic [bbr_pkg::ACTION_W-1:0]  out_act_ff;
   logic [bbr_pkg::SLOT_W-1:0]    out_slot_ff;
   bbr_pkg::block_type            out_blk_ff;
   logic                          out_last_ff;

   logic [bbr_pkg::USED_ENTRIES-1:0] hit_vec;
   logic [bbr_pkg::USED_ENTRIES-1:0] free_vec;
   logic                 hit_any, free_any, hit_sat;
   bbr_pkg::index_type   hit_idx, free_idx, rd_addr;
   bbr_pkg::refs_type    rd_refs;
   bbr_pkg::block_type   rd_block;
   logic                 put_ok;
   logic                 is_get, is_put;
   logic                 load;
   logic [bbr_pkg::ACTION_W-1:0] res_act;
   logic [bbr_pkg::SLOT_W-1:0]   res_slot;
   bbr_pkg::block_type           res_blk;
   logic                         res_last;

   assign is_get = (mode_ff == bbr_pkg::MODE_GET);
   assign is_put = (mode_ff == bbr_pkg::MODE_PUT);

   // parallel compare against every entry, lowest index wins
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      hit_sat  = 1'b0;
      for (int i = 0; i < bbr_pkg::USED_ENTRIES; i++) begin
         hit_vec[i]  = (refs_ff[i] != '0) && (block_ff[i] == blk_ff);
         free_vec[i] = (refs_ff[i] == '0);
      end
      for (int i = bbr_pkg::USED_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = bbr_pkg::index_type'(i);
            hit_sat = (refs_ff[i] == bbr_pkg::REF_MAX);
         end
         if (free_vec[i]) begin
            free_idx = bbr_pkg::index_type'(i);
         end
      end
   end

   assign hit_any  = |hit_vec;
   assign free_any = |free_vec;

   // single read port: scan position during a flush, entry index for a put
   assign rd_addr  = (mode_ff == bbr_pkg::MODE_FLUSH) ? scan_ff
                                                      : idx_ff[bbr_pkg::USED_W-1:0];
   assign rd_refs  = refs_ff[rd_addr];
   assign rd_block = block_ff[rd_addr];
   assign put_ok   = (int'(idx_ff) < bbr_pkg::USED_ENTRIES) && (rd_refs != '0);

   always_comb begin
      res_act  = bbr_pkg::ACT_ERROR;
      res_slot = '0;
      res_blk  = '0;
      res_last = 1'b1;
      priority if (cmd.flush_step) begin
         res_act  = bbr_pkg::ACT_FLUSH;
         res_slot = bbr_pkg::SLOT_W'(scan_ff);
         res_blk  = rd_block;
         res_last = 1'b0;
      end else if (cmd.flush_done) begin
         res_act = bbr_pkg::ACT_DONE;
      end else if (is_get) begin
         res_blk = blk_ff;
         if (hit_any) begin
            res_act  = hit_sat ? bbr_pkg::ACT_ERROR : bbr_pkg::ACT_HIT;
            res_slot = bbr_pkg::SLOT_W'(hit_idx);
         end else if (free_any) begin
            res_act  = bbr_pkg::ACT_ALLOC;
            res_slot = bbr_pkg::SLOT_W'(free_idx);
         end else begin
            res_act = bbr_pkg::ACT_FULL;
         end
      end else if (is_put) begin
         res_slot = idx_ff;
         if (put_ok) begin
            res_act = (rd_refs == bbr_pkg::REF_ONE) ? bbr_pkg::ACT_WRITEBACK
                                                    : bbr_pkg::ACT_RELEASED;
            res_blk = rd_block;
         end
      end else begin
         res_act = bbr_pkg::ACT_ERROR;
      end
   end

   assign load = cmd.exec || cmd.flush_done || (cmd.flush_step && (rd_refs != '0));

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_mode;
         blk_ff  <= req_block;
         idx_ff  <= req_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (cmd.latch) begin
         scan_ff <= '0;
      end else if (cmd.flush_step) begin
         scan_ff <= scan_ff + bbr_pkg::index_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bbr_pkg::USED_ENTRIES; i++) begin
            refs_ff[i] <= '0;
         end
      end else if (cmd.exec) begin
         for (int i = 0; i < bbr_pkg::USED_ENTRIES; i++) begin
            if (is_get && hit_any && !hit_sat && hit_idx == bbr_pkg::index_type'(i)) begin
               refs_ff[i] <= refs_ff[i] + bbr_pkg::REF_ONE;
            end
            if (is_get && !hit_any && free_any && free_idx == bbr_pkg::index_type'(i)) begin
               refs_ff[i] <= bbr_pkg::REF_ONE;
            end
            if (is_put && put_ok && rd_addr == bbr_pkg::index_type'(i)) begin
               refs_ff[i] <= refs_ff[i] - bbr_pkg::REF_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && is_get && !hit_any && free_any) begin
         block_ff[free_idx] <= blk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_act_ff  <= res_act;
         out_slot_ff <= res_slot;
         out_blk_ff  <= res_blk;
         out_last_ff <= res_last;
      end
   end

   assign status.out_free    = !out_valid_ff || rsp_tready;
   assign status.scan_active = (rd_refs != '0);
   assign status.scan_last   = (scan_ff == bbr_pkg::index_type'(bbr_pkg::USED_ENTRIES - 1));

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(bbr_pkg::RSP_DATA_W - bbr_pkg::BLOCK_W - bbr_pkg::SLOT_W){1'b0}},
                        out_blk_ff, out_slot_ff};
   assign rsp_tuser  = out_act_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ rtl/core/block_buffer_refcount_table.sv @@
// channel  direction  handshake          payload
// req      in         req_tvalid/tready  tdata: block, entry   tuser: mode
// rsp      out        rsp_tvalid/tready  tdata: slot, block    tuser: action  tlast: last
//
// a get, put or unused-mode transaction is captured, then the sixteen entries are searched
// in parallel and the result is loaded into the output register once that register is free
// a flush walks the table one entry per cycle through the single read port, but an active
// entry waits while the output register is held by a stalled consumer; free ones do not
// reset clears every reference count at once; block numbers are written before use
// a result held by a stalled consumer does not block capture of the next request

module block_buffer_refcount_table (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bbr_pkg::REQ_DATA_W-1:0]   req_tdata,   // block [15:0], entry [19:16]
   input  logic [bbr_pkg::MODE_W-1:0]       req_tuser,   // mode [1:0]
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bbr_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // slot [3:0], disk_block [19:4]
   output logic [bbr_pkg::ACTION_W-1:0]     rsp_tuser,   // action [2:0]
   output logic                             rsp_tlast    // last result of the transaction
);

   bbr_pkg::cmd_type    cmd;
   bbr_pkg::status_type status;

   logic [bbr_pkg::BLOCK_W-1:0] req_block;
   logic [bbr_pkg::ENTRY_W-1:0] req_entry;

   // unpack the request payload
   assign req_block = req_tdata[bbr_pkg::BLOCK_W-1:0];
   assign req_entry = req_tdata[bbr_pkg::BLOCK_W +: bbr_pkg::ENTRY_W];

   // sequencing of capture, execute and flush scan
   bbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // reference table, search logic and output register
   bbr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_mode   (req_tuser),
      .req_block  (req_block),
      .req_entry  (req_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/core/bbr_checker.sv @@
module bbr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [bbr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [bbr_pkg::MODE_W-1:0]       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [bbr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic [bbr_pkg::ACTION_W-1:0]     rsp_tuser,
   input  logic                             rsp_tlast
);

   // a stalled response holds its whole payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // only flush writes leave a transaction open
   a_last_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != bbr_pkg::ACT_FLUSH)))
      else $error("last flag does not match action");

   // done carries no slot or block, and padding stays zero
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bbr_pkg::ACT_DONE |-> rsp_tdata == '0)
      else $error("done result carries data");

endmodule

bind block_buffer_refcount_table bbr_checker u_bbr_checker (.*);
